// ===== src/sblc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_pkg: shared types for the sector buffer LRU directory
// Probe record that walks the cell chain, update command broadcast to the
// cells, and the controller state encoding.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int SECTOR_W = 31;
  localparam int STAMP_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int SLOT_W   = 4;

  // Search record carried from cell to cell (indexes travel beside it)
  typedef struct packed {
    logic                op;
    logic [SECTOR_W-1:0] sector;
    logic                drive_ok;
    logic                hit;
    logic                empty_found;
    logic [STAMP_W-1:0]  best_stamp;
  } probe_t;

  // Directory write command, applied by every cell at the same edge
  typedef struct packed {
    logic                clear_all;
    logic                fill;
    logic                touch;
    logic [SECTOR_W-1:0] sector;
    logic [STAMP_W-1:0]  stamp;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

endpackage

// ===== src/sblc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_cell: one directory entry of the sector buffer chain
// Holds valid, sector and stamp of one buffer, folds its entry into the
// passing probe (hit, first empty, smallest stamp) and registers the result
// for the next cell. Applies broadcast directory updates.
// ----------------------------------------------------------------------------
module sblc_cell #(
  parameter int IDX  = 0,
  parameter int IW   = 4,
  parameter int CNTW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CNTW-1:0] n_eff,
  input  logic            pin_valid,
  input  sblc_pkg::probe_t pin,
  input  logic [IW-1:0]   pin_hit_idx,
  input  logic [IW-1:0]   pin_empty_idx,
  input  logic [IW-1:0]   pin_best_idx,
  output logic            pout_valid,
  output sblc_pkg::probe_t pout,
  output logic [IW-1:0]   pout_hit_idx,
  output logic [IW-1:0]   pout_empty_idx,
  output logic [IW-1:0]   pout_best_idx,
  input  sblc_pkg::upd_t  upd,
  input  logic [IW-1:0]   upd_idx
);
  import sblc_pkg::*;

  localparam logic [IW-1:0]   MY_IDX  = IW'(IDX);
  localparam logic [CNTW-1:0] MY_CNT  = CNTW'(IDX);
  localparam bit              IS_HEAD = (IDX == 0);

  logic                entry_valid;
  logic [SECTOR_W-1:0] entry_sector;
  logic [STAMP_W-1:0]  entry_stamp;

  probe_t        probe_next;
  logic [IW-1:0] hit_idx_next;
  logic [IW-1:0] empty_idx_next;
  logic [IW-1:0] best_idx_next;
  logic          active;

  // Fold this entry into the probe
  always_comb begin
    active         = (MY_CNT < n_eff);
    probe_next     = pin;
    hit_idx_next   = pin_hit_idx;
    empty_idx_next = pin_empty_idx;
    best_idx_next  = pin_best_idx;
    if (active) begin
      if (!pin.hit && entry_valid && (entry_sector == pin.sector)) begin
        probe_next.hit = 1'b1;
        hit_idx_next   = MY_IDX;
      end
      if (!pin.empty_found && !entry_valid) begin
        probe_next.empty_found = 1'b1;
        empty_idx_next         = MY_IDX;
      end
      // strict compare keeps the lowest slot on a tie
      if (IS_HEAD || (entry_stamp < pin.best_stamp)) begin
        probe_next.best_stamp = entry_stamp;
        best_idx_next         = MY_IDX;
      end
    end
  end

  // Hand the probe to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      pout_valid <= 1'b0;
    end else begin
      pout_valid <= pin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_valid) begin
      pout           <= probe_next;
      pout_hit_idx   <= hit_idx_next;
      pout_empty_idx <= empty_idx_next;
      pout_best_idx  <= best_idx_next;
    end
  end

  // Apply directory updates
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      entry_stamp <= '0;
    end else if (upd.clear_all) begin
      entry_valid <= 1'b0;
    end else if (upd.fill && (upd_idx == MY_IDX)) begin
      entry_valid <= 1'b1;
      entry_stamp <= upd.stamp;
    end else if (upd.touch && (upd_idx == MY_IDX)) begin
      entry_stamp <= upd.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.fill && !upd.clear_all && (upd_idx == MY_IDX)) begin
      entry_sector <= upd.sector;
    end
  end

endmodule

// ===== src/sector_buffer_lru_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_buffer_lru_cache: fully associative sector buffer directory
// Timestamp LRU replacement over a chain of entry cells; lookup, fill on
// drive success, flush on drive failure or on a clear transaction.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_*       in         tdata: sector[30:0], drive_ok[31]; tuser: operation[0]
//  m_*       out        tdata: hit[0], slot[4:1], read_issued[5], ok[6]
//  cfg_*     in         cfg_wdata: buffers_in_use[4:0]
//
//  No transaction is accepted until the previous one is through: the probe
//  walks the cell chain one cell per cycle, then the decision state decides,
//  writes the directory and loads the result.
//  A finished result waits in the output register; the decision cycle holds
//  while a previous result is still not taken. Reset is synchronous and
//  empties the directory; it leaves no clearing pass.
// ----------------------------------------------------------------------------
module sector_buffer_lru_cache #(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sector[30:0], drive_ok[31]
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // hit[0], slot[4:1], read_issued[5], ok[6], zero
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import sblc_pkg::*;

  localparam int IW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNTW = $clog2(NUM_BUFFERS + 1);
  localparam int CMPW = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam logic [CMPW-1:0] MAX_CNT = CMPW'(NUM_BUFFERS);

  logic [COUNT_W-1:0] buffers_in_use;
  logic [CNTW-1:0]    n_eff;
  logic [CMPW-1:0]    biu_ext;
  logic [STAMP_W-1:0] tick;
  state_t             state, state_next;

  logic                  accept;
  logic [NUM_BUFFERS:0]  chain_valid;
  probe_t                chain_probe     [NUM_BUFFERS+1];
  logic [IW-1:0]         chain_hit_idx   [NUM_BUFFERS+1];
  logic [IW-1:0]         chain_empty_idx [NUM_BUFFERS+1];
  logic [IW-1:0]         chain_best_idx  [NUM_BUFFERS+1];

  upd_t          upd;
  logic [IW-1:0] upd_idx;
  logic          fire;
  probe_t        lp;
  logic [IW-1:0] loc;
  logic          res_hit, res_read, res_ok;
  logic [IW-1:0] res_idx;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffers_in_use <= COUNT_W'(16);
    end else if (cfg_we) begin
      buffers_in_use <= cfg_wdata;
    end
  end

  // Saturate the buffer count into 1..NUM_BUFFERS
  always_comb begin
    biu_ext = CMPW'(buffers_in_use);
    if (biu_ext == '0) begin
      n_eff = CNTW'(1);
    end else if (biu_ext > MAX_CNT) begin
      n_eff = CNTW'(NUM_BUFFERS);
    end else begin
      n_eff = CNTW'(biu_ext);
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Feed the head of the chain straight from the input
  always_comb begin
    chain_valid[0]          = accept;
    chain_probe[0]          = '0;
    chain_probe[0].op       = s_tuser[0];
    chain_probe[0].sector   = s_tdata[30:0];
    chain_probe[0].drive_ok = s_tdata[31];
    chain_hit_idx[0]        = '0;
    chain_empty_idx[0]      = '0;
    chain_best_idx[0]       = '0;
  end

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    sblc_cell #(
      .IDX  (i),
      .IW   (IW),
      .CNTW (CNTW)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .n_eff          (n_eff),
      .pin_valid      (chain_valid[i]),
      .pin            (chain_probe[i]),
      .pin_hit_idx    (chain_hit_idx[i]),
      .pin_empty_idx  (chain_empty_idx[i]),
      .pin_best_idx   (chain_best_idx[i]),
      .pout_valid     (chain_valid[i+1]),
      .pout           (chain_probe[i+1]),
      .pout_hit_idx   (chain_hit_idx[i+1]),
      .pout_empty_idx (chain_empty_idx[i+1]),
      .pout_best_idx  (chain_best_idx[i+1]),
      .upd            (upd),
      .upd_idx        (upd_idx)
    );
  end

  // Advance the access tick on each accepted lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (accept && (s_tuser[0] == OP_LOOKUP)) begin
      tick <= tick + 1'b1;
    end
  end

  // Controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign fire = (state == ST_FINISH) && (!m_tvalid || m_tready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (chain_valid[NUM_BUFFERS]) state_next = ST_FINISH;
      ST_FINISH: if (fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Decide hit, fill or flush from the probe at the chain end
  always_comb begin
    lp         = chain_probe[NUM_BUFFERS];
    loc        = lp.empty_found ? chain_empty_idx[NUM_BUFFERS] : chain_best_idx[NUM_BUFFERS];
    upd        = '0;
    upd.sector = lp.sector;
    upd.stamp  = tick;
    upd_idx    = loc;
    res_hit    = 1'b0;
    res_read   = 1'b0;
    res_ok     = 1'b1;
    res_idx    = '0;
    if (lp.op == OP_CLEAR) begin
      upd.clear_all = fire;
    end else if (lp.hit) begin
      upd.touch = fire;
      upd_idx   = chain_hit_idx[NUM_BUFFERS];
      res_hit   = 1'b1;
      res_idx   = chain_hit_idx[NUM_BUFFERS];
    end else if (lp.drive_ok) begin
      upd.fill = fire;
      res_read = 1'b1;
      res_idx  = loc;
    end else begin
      upd.clear_all = fire;
      res_read      = 1'b1;
      res_ok        = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, res_ok, res_read, SLOT_W'(res_idx), res_hit};
    end
  end

`ifndef NO_ASSERTIONS
  // at most one transaction in the chain
  a_one_in_chain: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid[NUM_BUFFERS:1]))
    else $error("more than one probe in the cell chain");

  // no acceptance while a transaction is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while busy");

  // a result appears only from the decision cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside the decision cycle");

  // a lookup advances the tick by one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser[0] == OP_LOOKUP) |=> tick == $past(tick) + 32'd1)
    else $error("access tick did not advance");
`endif

endmodule

// ===== tb/tb_sector_buffer_lru_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_buffer_lru_cache: self-checking bench for the sector directory
// Streams lookup and clear transactions through the directory at several
// buffer-count settings. The bench keeps its own LRU directory image,
// predicts hit, slot, read and status for every transaction, and compares
// them against the result stream under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_sector_buffer_lru_cache;
  import sblc_pkg::*;

  // One input transaction
  typedef struct packed {
    logic                op;
    logic [SECTOR_W-1:0] sector;
    logic                drive_ok;
  } lookup_item_t;

  // One result transaction, hit in the lowest bit
  typedef struct packed {
    logic              ok;
    logic              read_issued;
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } dir_result_t;

  // Directory image and queue of expected results
  class sector_dir_scoreboard;
    localparam int NBUF = 16;

    bit                ent_valid  [NBUF];
    bit [SECTOR_W-1:0] ent_sector [NBUF];
    bit [STAMP_W-1:0]  ent_stamp  [NBUF];
    bit [STAMP_W-1:0]  tick;
    bit [COUNT_W-1:0]  buf_count;
    dir_result_t       exp_q[$];

    int unsigned errors;
    int unsigned lookups, hits, fills, drive_fails, clears;

    function new();
      buf_count = 5'd16;
      tick      = '0;
      foreach (ent_valid[i]) begin
        ent_valid[i]  = 1'b0;
        ent_sector[i] = '0;
        ent_stamp[i]  = '0;
      end
    endfunction

    function void set_count(bit [COUNT_W-1:0] value);
      buf_count = value;
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    // Saturate the programmed count into 1..NBUF
    function int active_entries();
      int n;
      n = int'(buf_count);
      if (n < 1) n = 1;
      if (n > NBUF) n = NBUF;
      return n;
    endfunction

    function void flush_dir();
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    // Advance the directory image by one accepted transaction
    function void note_item(lookup_item_t it);
      dir_result_t r;
      int          n;
      int          loc;
      bit          found;
      r     = '0;
      found = 1'b0;
      if (it.op == OP_CLEAR) begin
        flush_dir();
        r.ok = 1'b1;
        clears++;
      end else begin
        lookups++;
        tick = tick + 1;
        n    = active_entries();
        for (int i = 0; i < n; i++) begin
          if (ent_valid[i] && ent_sector[i] == it.sector) begin
            ent_stamp[i] = tick;
            r.hit  = 1'b1;
            r.slot = i[SLOT_W-1:0];
            r.ok   = 1'b1;
            found  = 1'b1;
            hits++;
            break;
          end
        end
        if (!found) begin
          r.read_issued = 1'b1;
          // First empty entry, else the oldest stamp with the lowest slot on a tie
          loc = -1;
          for (int i = 0; i < n; i++) begin
            if (!ent_valid[i]) begin
              loc = i;
              break;
            end
          end
          if (loc < 0) begin
            loc = 0;
            for (int i = 1; i < n; i++)
              if (ent_stamp[i] < ent_stamp[loc]) loc = i;
          end
          if (it.drive_ok) begin
            ent_valid[loc]  = 1'b1;
            ent_sector[loc] = it.sector;
            ent_stamp[loc]  = tick;
            r.slot = loc[SLOT_W-1:0];
            r.ok   = 1'b1;
            fills++;
          end else begin
            flush_dir();
            drive_fails++;
          end
        end
      end
      exp_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [7:0] data);
      dir_result_t got;
      dir_result_t want;
      got = data[6:0];
      if (exp_q.size() == 0) begin
        $error("result transaction 0x%02h with no expectation pending", data);
        errors++;
      end else begin
        want = exp_q.pop_front();
        compare_field("hit", want.hit, got.hit);
        compare_field("slot", want.slot, got.slot);
        compare_field("read_issued", want.read_issued, got.read_issued);
        compare_field("ok", want.ok, got.ok);
      end
    endfunction
  endclass

  localparam int NUM_BUFFERS   = 16;
  localparam int ITEMS_PER_SET = 141;
  localparam int RX_HOLD       = 300;
  localparam int NUM_SETS      = 8;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [31:0] s_tdata;
  logic [0:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  sector_dir_scoreboard sb = new();

  logic [SECTOR_W-1:0] sector_pool[$];
  int unsigned         burst_left;
  bit                  gaps_on;
  int unsigned         rx_mode;
  bit                  rx_hold_req;
  int unsigned         settings_run;

  sector_buffer_lru_cache #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Sink: stall pattern per mode, with one long hold-off on request
  initial begin
    int unsigned held;
    int unsigned rx_cnt;
    m_tready = 1'b0;
    rx_cnt   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        held = 1;
        while (held < RX_HOLD) begin
          @(negedge clk);
          held++;
        end
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(3) != 0);
          2: m_tready <= (rx_cnt % 3 == 0);
          default: m_tready <= ($urandom_range(3) == 0);
        endcase
        rx_cnt++;
      end
    end
  end

  // Check each accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input lookup_item_t it);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.drive_ok, it.sector};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    sb.note_item(it);
  endtask

  // Drop valid and idle the source
  task automatic idle_sender(input int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Send in bursts with random gaps between them when gaps are on
  task automatic send_paced(input lookup_item_t it);
    if (burst_left == 0) begin
      if (gaps_on) idle_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    send_item(it);
    burst_left--;
  endtask

  // Stop the source, wait for every expected result, then let the cell chain settle
  task automatic drain();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_BUFFERS + 4) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_count(value);
    settings_run++;
  endtask

  function automatic lookup_item_t make_lookup(input logic [SECTOR_W-1:0] sector,
                                               input logic drive_ok);
    lookup_item_t it;
    it.op       = OP_LOOKUP;
    it.sector   = sector;
    it.drive_ok = drive_ok;
    return it;
  endfunction

  // Mostly pooled sectors so hits and evictions both occur
  function automatic lookup_item_t make_random_item();
    lookup_item_t it;
    int unsigned  r;
    r = $urandom_range(99);
    it.sector   = SECTOR_W'($urandom());
    it.drive_ok = ($urandom_range(99) < 94);
    it.op       = (r < 3) ? OP_CLEAR : OP_LOOKUP;
    if (it.op == OP_LOOKUP && r < 88)
      it.sector = sector_pool[$urandom_range(sector_pool.size() - 1)];
    return it;
  endfunction

  // Rebuild the pool, keeping about half of the old sectors
  function automatic void refresh_pool(input int unsigned size);
    logic [SECTOR_W-1:0] fresh[$];
    logic [SECTOR_W-1:0] s;
    for (int k = 0; k < size; k++) begin
      s = SECTOR_W'($urandom());
      if (k < sector_pool.size() && $urandom_range(1)) s = sector_pool[k];
      if ($urandom_range(19) == 0) s = $urandom_range(1) ? '0 : '1;
      fresh.push_back(s);
    end
    sector_pool = fresh;
  endfunction

  // Main sequence
  initial begin
    logic [4:0]   set_values[NUM_SETS];
    int unsigned  eff;
    lookup_item_t clr;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    burst_left   = 0;
    gaps_on      = 1'b0;
    rx_mode      = 0;
    rx_hold_req  = 1'b0;
    settings_run = 1;
    set_values   = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd9, 5'd2, 5'd16};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, hit, clear, drive failure, full fill, eviction
    clr = '{op: OP_CLEAR, sector: 31'h2AAAAAAA, drive_ok: 1'b0};
    send_item(make_lookup('0, 1'b1));
    send_item(make_lookup('1, 1'b1));
    send_item(make_lookup('0, 1'b0));
    send_item(make_lookup(31'h55555555, 1'b1));
    send_item(make_lookup(31'h2AAAAAAA, 1'b1));
    send_item(clr);
    send_item(make_lookup('0, 1'b1));
    send_item(make_lookup(31'd5, 1'b0));
    for (int k = 0; k < NUM_BUFFERS; k++)
      send_item(make_lookup(SECTOR_W'(100 + k), 1'b1));
    send_item(make_lookup(31'd100, 1'b1));
    send_item(make_lookup(31'd200, 1'b1));
    drain();

    // Random phases, one per buffer-count setting
    for (int p = 0; p < NUM_SETS; p++) begin
      write_count(set_values[p]);
      eff = (set_values[p] < 1) ? 1 : (set_values[p] > NUM_BUFFERS) ? NUM_BUFFERS
                                                                   : set_values[p];
      refresh_pool(eff + $urandom_range(1, 8));
      rx_mode    = p % 4;
      gaps_on    = (p % 3 != 0);
      burst_left = 0;
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        // Long sink hold-off while the source keeps offering
        if (p == 4 && k == 30) rx_hold_req = 1'b1;
        send_paced(make_random_item());
      end
      drain();
    end

    $display("Covered %0d lookups (%0d hits, %0d fills, %0d drive failures), %0d clears,",
             sb.lookups, sb.hits, sb.fills, sb.drive_fails, sb.clears);
    $display("over %0d buffer-count settings with source gaps and sink stalls.",
             settings_run);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
